[sv/lwd_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS window decoder package
// Shared constants, codes and beat types for the LZSS window decoder.
// ----------------------------------------------------------------------------
package lwd_pkg;

  // Window and match geometry
  localparam int POS_BITS   = 14;
  localparam int LEN_BITS   = 4;
  localparam int MIN_MATCH  = 3;
  localparam int WIN_SIZE   = 1 << POS_BITS;
  localparam int STAGE_SIZE = (1 << LEN_BITS) + MIN_MATCH;
  localparam int CNT_W      = $clog2(STAGE_SIZE + 1);
  localparam int IDX_W      = $clog2(STAGE_SIZE);

  // Token action codes
  localparam logic [1:0] ACT_LITERAL = 2'd0;
  localparam logic [1:0] ACT_SHORT   = 2'd1;
  localparam logic [1:0] ACT_LONG    = 2'd2;

  // Input beat: one token
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  literal_byte;
    logic [3:0]  length_code;
    logic [13:0] match_position;
  } lwd_in_t;

  // Output beat: one decoded byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } lwd_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_lit;
    logic             load_match;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             emit;
    logic [IDX_W-1:0] emit_idx;
    logic             emit_last;
  } lwd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } lwd_sts_t;

endpackage

[sv/lwd_ctrl.sv]
// ----------------------------------------------------------------------------
// LZSS window decoder controller
// Sequences each match token through a window read phase and a byte emit phase;
// a literal goes straight to the emit phase and an unused action is dropped.
module lwd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lwd_pkg::lwd_in_t in_data,
  output lwd_pkg::lwd_cmd_t cmd,
  input  lwd_pkg::lwd_sts_t sts
);
  import lwd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             at_end;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign at_end   = (cnt_r == (len_r - CNT_W'(1)));

  // Next-state and command decode
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          priority case (in_data.action)
            ACT_LITERAL: begin
              cmd.load_lit = 1'b1;
              len_nxt      = CNT_W'(1);
              state_nxt    = ST_EMIT;
            end
            ACT_SHORT: begin
              cmd.load_match = 1'b1;
              len_nxt        = CNT_W'(MIN_MATCH);
              state_nxt      = ST_READ;
            end
            ACT_LONG: begin
              cmd.load_match = 1'b1;
              len_nxt        = CNT_W'(MIN_MATCH + 1)
                               + CNT_W'(in_data.length_code[LEN_BITS-1:0]);
              state_nxt      = ST_READ;
            end
            default: begin
              // Unused action: the token is dropped without effect.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt_r[IDX_W-1:0];
        if (at_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_idx  = cnt_r[IDX_W-1:0];
          cmd.emit_last = at_end;
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (at_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[sv/lwd_datapath.sv]
// ----------------------------------------------------------------------------
// LZSS window decoder datapath
// History window memory, match staging buffer, write pointer and output
// register.
// ----------------------------------------------------------------------------
module lwd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lwd_pkg::lwd_in_t  in_data,
  input  lwd_pkg::lwd_cmd_t cmd,
  output lwd_pkg::lwd_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output lwd_pkg::lwd_out_t out_data
);
  import lwd_pkg::*;

  logic [7:0]          win_mem [WIN_SIZE];
  logic [7:0]          stg_r   [STAGE_SIZE];
  logic [POS_BITS-1:0] rd_addr_r, rd_addr_nxt;
  logic [POS_BITS-1:0] wp_r, wp_nxt;
  logic                full_r, full_nxt;
  logic [7:0]          mem_q_r;
  logic                vld_q_r;
  logic                pend_r;
  logic [IDX_W-1:0]    pend_idx_r;
  logic                out_valid_r, out_valid_nxt;
  lwd_out_t            out_r;
  logic [7:0]          emit_byte;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign emit_byte    = stg_r[cmd.emit_idx];

  // Read address walks from the match position and wraps with the window.
  always_comb begin
    rd_addr_nxt = rd_addr_r;
    if (cmd.load_match) begin
      rd_addr_nxt = in_data.match_position[POS_BITS-1:0];
    end else if (cmd.rd_en) begin
      rd_addr_nxt = rd_addr_r + POS_BITS'(1);
    end
  end

  // The window is filled in write-pointer order from reset, so an entry
  // at or above the pointer is unwritten until the pointer first wraps.
  always_comb begin
    wp_nxt   = wp_r;
    full_nxt = full_r;
    if (cmd.emit) begin
      wp_nxt = wp_r + POS_BITS'(1);
      if (wp_r == {POS_BITS{1'b1}}) begin
        full_nxt = 1'b1;
      end
    end
  end

  // Output register is refilled on emit and emptied when its beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Window memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q_r <= win_mem[rd_addr_r];
      vld_q_r <= full_r || (rd_addr_r < wp_r);
    end
    if (cmd.emit) begin
      win_mem[wp_r] <= emit_byte;
    end
  end

  // Staging buffer takes the literal or the returning window read.
  always_ff @(posedge clk) begin
    pend_idx_r <= cmd.rd_idx;
    if (cmd.load_lit) begin
      stg_r[0] <= in_data.literal_byte;
    end else if (pend_r) begin
      stg_r[pend_idx_r] <= vld_q_r ? mem_q_r : 8'd0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_byte <= emit_byte;
      out_r.last     <= cmd.emit_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_addr_r   <= rd_addr_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      pend_r      <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/lzss_window_decoder.sv]
// ----------------------------------------------------------------------------
// LZSS window decoder
// Turns separated LZSS tokens into decoded bytes using a 16K-byte history
// window.
//
//   Channel | Ports                          | Beat
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data    | one token
//   output  | out_valid, out_ready, out_data | one decoded byte, last on final
//
// A literal passes through the staging buffer into the output register.
// A match of L bytes makes L window reads into the staging buffer and then
// L byte emits; the window's single read port serialises the reads.
// Reset clears the write pointer; unwritten window bytes read as zero
// through a fill marker, so there is no clearing pass after reset.
// An output stall holds the emit phase; a new token is taken once the
// final byte of the current one has entered the output register.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lwd_pkg::lwd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lwd_pkg::lwd_out_t out_data
);
  import lwd_pkg::*;

  lwd_cmd_t cmd;
  lwd_sts_t sts;

  // Token sequencer
  lwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Window, staging and output register
  lwd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/lwd_checker.sv]
// ----------------------------------------------------------------------------
// LZSS window decoder checker
// Port-level assertions on token and byte sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module lwd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input lwd_pkg::lwd_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input lwd_pkg::lwd_out_t out_data
);
  import lwd_pkg::*;

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // A literal into an empty output register passes through the staging buffer to the output, marked last.
  a_lit_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_LITERAL) && !out_valid
    |-> ##2 out_valid && out_data.last
            && (out_data.out_byte == $past(in_data.literal_byte, 2)))
    else $error("literal byte not emitted as expected");

  // While a token still has bytes to emit, no new token is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |-> !in_ready)
    else $error("token accepted during an unfinished match");

  // An unused action leaves the decoder ready for the next token.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action != ACT_LITERAL)
      && (in_data.action != ACT_SHORT) && (in_data.action != ACT_LONG)
    |=> in_ready)
    else $error("unused action was not dropped");

endmodule

bind lzss_window_decoder lwd_checker u_lwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
